>>> src/skt_pkg.sv
package skt_pkg;

	localparam int CAPACITY = 64;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int OP_W      = 2;
	localparam int KEY_W     = 32;
	localparam int POS_W     = 6;
	localparam int ENTRIES_W = 7;

	localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_FOUND  = 2'd0,
		ST_DONE   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		status_t                status;
		logic [POS_W-1:0]       position;
		logic [ENTRIES_W-1:0]   entry_count;
	} result_t;

endpackage

>>> src/skt_ram.sv
module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/skt_seq.sv
module skt_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [skt_pkg::OP_W-1:0]    op,
	input  logic [skt_pkg::KEY_W-1:0]   key,
	input  logic                        take,
	output logic                        idle,
	output logic                        done,
	output skt_pkg::result_t            res
);

	localparam int IDX_W = skt_pkg::IDX_W;
	localparam int CNT_W = skt_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SADDR,
		S_SCMP,
		S_DECIDE,
		S_SHIFT,
		S_WRKEY,
		S_FINISH
	} state_t;

	state_t                      state_q;
	logic [skt_pkg::OP_W-1:0]    op_q;
	logic [skt_pkg::KEY_W-1:0]   key_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            lo_q;
	logic [CNT_W-1:0]            hi_q;
	logic [IDX_W-1:0]            mid_q;
	logic                        hit_q;
	logic                        ins_q;
	logic [CNT_W-1:0]            mv_q;
	logic [IDX_W-1:0]            rp_q;
	logic                        pend_q;
	logic [IDX_W-1:0]            pwa_q;
	skt_pkg::status_t            status_q;
	logic [CNT_W-1:0]            rpos_q;

	logic [CNT_W:0]              sum_w;
	logic [IDX_W-1:0]            mid_w;
	logic                        we_w;
	logic [IDX_W-1:0]            waddr_w;
	logic [skt_pkg::KEY_W-1:0]   wdata_w;
	logic [IDX_W-1:0]            raddr_w;
	logic [skt_pkg::KEY_W-1:0]   rdata_w;

	assign sum_w = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(hi_q);
	assign mid_w = IDX_W'(sum_w >> 1);

	assign raddr_w = (state_q == S_SADDR) ? mid_w : rp_q;
	assign we_w    = ((state_q == S_SHIFT) && pend_q) || (state_q == S_WRKEY);
	assign waddr_w = (state_q == S_WRKEY) ? IDX_W'(lo_q) : pwa_q;
	assign wdata_w = (state_q == S_WRKEY) ? key_q : rdata_w;

	skt_ram #(
		.WIDTH(skt_pkg::KEY_W),
		.DEPTH(skt_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we_w),
		.waddr(waddr_w),
		.wdata(wdata_w),
		.raddr(raddr_w),
		.rdata(rdata_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			key_q    <= '0;
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			hit_q    <= 1'b0;
			ins_q    <= 1'b0;
			mv_q     <= '0;
			rp_q     <= '0;
			pend_q   <= 1'b0;
			pwa_q    <= '0;
			status_q <= skt_pkg::ST_ABSENT;
			rpos_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						key_q   <= key;
						lo_q    <= '0;
						hi_q    <= count_q;
						hit_q   <= 1'b0;
						state_q <= S_SADDR;
					end
				end
				S_SADDR: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w;
						state_q <= S_SCMP;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_SCMP: begin
					if (rdata_w < key_q) begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end else begin
						hi_q <= CNT_W'(mid_q);
					end
					if (rdata_w == key_q) begin
						hit_q <= 1'b1;
					end
					state_q <= S_SADDR;
				end
				S_DECIDE: begin
					pend_q <= 1'b0;
					priority if (op_q == skt_pkg::OP_GET) begin
						if (hit_q) begin
							status_q <= skt_pkg::ST_FOUND;
							rpos_q   <= lo_q;
							state_q  <= S_FINISH;
						end else if (count_q >= CNT_W'(skt_pkg::CAPACITY)) begin
							status_q <= skt_pkg::ST_FULL;
							rpos_q   <= '0;
							state_q  <= S_FINISH;
						end else begin
							status_q <= skt_pkg::ST_DONE;
							rpos_q   <= lo_q;
							ins_q    <= 1'b1;
							mv_q     <= count_q - lo_q;
							rp_q     <= IDX_W'(count_q - CNT_W'(1));
							count_q  <= count_q + CNT_W'(1);
							state_q  <= S_SHIFT;
						end
					end else if (op_q == skt_pkg::OP_REMOVE) begin
						if (hit_q) begin
							status_q <= skt_pkg::ST_DONE;
							rpos_q   <= lo_q;
							ins_q    <= 1'b0;
							mv_q     <= count_q - lo_q - CNT_W'(1);
							rp_q     <= IDX_W'(lo_q + CNT_W'(1));
							count_q  <= count_q - CNT_W'(1);
							state_q  <= S_SHIFT;
						end else begin
							status_q <= skt_pkg::ST_ABSENT;
							rpos_q   <= '0;
							state_q  <= S_FINISH;
						end
					end else begin
						status_q <= hit_q ? skt_pkg::ST_FOUND : skt_pkg::ST_ABSENT;
						rpos_q   <= hit_q ? lo_q : '0;
						state_q  <= S_FINISH;
					end
				end
				S_SHIFT: begin
					if (mv_q != '0) begin
						pend_q <= 1'b1;
						pwa_q  <= ins_q ? rp_q + IDX_W'(1) : rp_q - IDX_W'(1);
						rp_q   <= ins_q ? rp_q - IDX_W'(1) : rp_q + IDX_W'(1);
						mv_q   <= mv_q - CNT_W'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= ins_q ? S_WRKEY : S_FINISH;
					end
				end
				S_WRKEY: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FINISH);
	assign res  = {status_q, skt_pkg::POS_W'(rpos_q), skt_pkg::ENTRIES_W'(count_q)};

	// search window stays inside the held keys
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SADDR) |-> (lo_q <= hi_q) && (hi_q <= count_q))
		else $error("search window out of range");

	// the count only moves after the decision step
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == S_DECIDE))
		else $error("entry count changed outside decision");

	// full is reported only when the table is full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && (status_q == skt_pkg::ST_FULL)
		|-> (count_q == CNT_W'(skt_pkg::CAPACITY)))
		else $error("full reported with free entries");

	// the store is written only while moving keys or placing the new key
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		we_w |-> (ins_q || (status_q == skt_pkg::ST_DONE)) && (count_q != '0 || !ins_q))
		else $error("store written outside an update");

endmodule

>>> src/sorted_key_table.sv
// Sorted key table: a set of up to CAPACITY distinct 32-bit keys kept in
// ascending order in a single-port-read, single-port-write RAM.
// Request channel (req_valid/req_ready): operation (find, get-or-insert,
// remove) and key. req_ready is high only while the sequencer is idle.
// Response channel (rsp_valid/rsp_ready): status, position, entry_count,
// one response per request, in request order.
// Each binary-search probe is a RAM read followed by a compare, with up to
// ceil(log2(n+1)) probes for n held keys, then a decision step. Find,
// hits and full/absent outcomes then go to the response register. Insert
// and remove then move the larger keys one entry per cycle through the
// RAM, and insert then writes the new key. The worst case is a remove of
// the smallest of 64 keys.
// The shared RAM read port and comparator set the pace of the search.
// Reset clears the entry count; the key RAM needs no clearing since only
// entries below the count are used. The block accepts a request right
// after reset.
// A stalled receiver holds the response register; a finished result waits
// in the sequencer until the register frees, and no new request is taken.
module sorted_key_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [skt_pkg::OP_W-1:0]            operation,
	input  logic [skt_pkg::KEY_W-1:0]           key,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [1:0]                          status,
	output logic [skt_pkg::POS_W-1:0]           position,
	output logic [skt_pkg::ENTRIES_W-1:0]       entry_count
);

	logic              idle_w;
	logic              done_w;
	logic              take_w;
	skt_pkg::result_t  res_w;
	skt_pkg::result_t  rsp_q;
	logic              rsp_valid_q;

	assign take_w = done_w && (!rsp_valid_q || rsp_ready);

	skt_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (req_valid && idle_w),
		.op    (operation),
		.key   (key),
		.take  (take_w),
		.idle  (idle_w),
		.done  (done_w),
		.res   (res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take_w) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_w) begin
			rsp_q <= res_w;
		end
	end

	assign req_ready   = idle_w;
	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign position    = rsp_q.position;
	assign entry_count = rsp_q.entry_count;

endmodule

>>> verif/sorted_key_table_checker.sv
module sorted_key_table_checker
	import skt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  logic [OP_W-1:0]      operation,
	input  logic [KEY_W-1:0]     key,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  logic [1:0]           status,
	input  logic [POS_W-1:0]     position,
	input  logic [ENTRIES_W-1:0] entry_count,
	output int                   fail_count,
	output int                   results_due
);

	logic [KEY_W-1:0] held_keys [CAPACITY];
	int               held_n;
	result_t          lookups_due [$];
	int               mismatches = 0;

	assign fail_count  = mismatches;
	assign results_due = lookups_due.size();

	// Applies one request to the shadow table and returns the response it yields.
	function automatic result_t table_lookup_update(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] k);
		result_t r;
		int      slot;
		int      i;
		bit      hit;
		slot = 0;
		while (slot < held_n && held_keys[slot] < k)
			slot++;
		hit = (slot < held_n) && (held_keys[slot] == k);
		r.status = ST_ABSENT;
		r.position = '0;
		case (op)
			OP_GET: begin
				if (hit) begin
					r.status = ST_FOUND;
					r.position = POS_W'(slot);
				end else if (held_n >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = held_n; i > slot; i--)
						held_keys[i] = held_keys[i-1];
					held_keys[slot] = k;
					held_n++;
					r.status = ST_DONE;
					r.position = POS_W'(slot);
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					for (i = slot; i + 1 < held_n; i++)
						held_keys[i] = held_keys[i+1];
					held_n--;
					r.status = ST_DONE;
					r.position = POS_W'(slot);
				end
			end
			default: begin
				// find, and the unused code behaves as find
				if (hit) begin
					r.status = ST_FOUND;
					r.position = POS_W'(slot);
				end
			end
		endcase
		r.entry_count = ENTRIES_W'(held_n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held_n = 0;
			lookups_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (lookups_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected response: status=%0d position=%0d count=%0d",
							status, position, entry_count);
					mismatches++;
				end else begin
					want = lookups_due.pop_front();
					if (status !== want.status || position !== want.position ||
							entry_count !== want.entry_count) begin
						if (mismatches < 10) begin
							$display("response mismatch: expected status=%0d position=%0d count=%0d,",
								want.status, want.position, want.entry_count);
							$display("  got status=%0d position=%0d count=%0d",
								status, position, entry_count);
						end
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				lookups_due.push_back(table_lookup_update(operation, key));
		end
	end

endmodule

>>> verif/sorted_key_table_tb.sv
module sorted_key_table_tb;
	import skt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int POOL_N = 96;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [OP_W-1:0]      operation = OP_FIND;
	logic [KEY_W-1:0]     key = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	logic [1:0]           status;
	logic [POS_W-1:0]     position;
	logic [ENTRIES_W-1:0] entry_count;
	int                   fail_count;
	int                   results_due;

	logic [KEY_W-1:0] key_pool [POOL_N];
	bit               send_idle = 1'b1;
	bit               recv_idle = 1'b1;

	always #5 clk = ~clk;

	sorted_key_table u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .key(key),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .position(position), .entry_count(entry_count)
	);

	sorted_key_table_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .key(key),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .position(position), .entry_count(entry_count),
		.fail_count(fail_count), .results_due(results_due)
	);

	// Entered right after an edge where the previous request was taken.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_idle = !send_idle;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key <= k;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int n, input int get_pct, input int remove_pct);
		int               pick;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < get_pct)
				op = OP_GET;
			else if (pick < get_pct + remove_pct)
				op = OP_REMOVE;
			else
				op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_FIND;
			k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N-1)]
				: $urandom;
			send_request(op, k);
		end
	endtask

	// response side
	initial begin
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_idle = !recv_idle;
			gap = recv_idle ? $urandom_range(0, 19) : 0;
			// long hold-off so the block backs up into the request side
			if (taken == 300)
				gap = 400;
			@(negedge clk);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h0000_0001;
		key_pool[3] = 32'hFFFF_FFFE;
		key_pool[4] = 32'h8000_0000;
		key_pool[5] = 32'h7FFF_FFFF;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_FIND,   32'h0000_0000);
		send_request(OP_REMOVE, 32'h0000_0005);
		send_request(OP_UNUSED, 32'h0000_0000);
		send_request(OP_GET,    32'h8000_0000);
		send_request(OP_GET,    32'h0000_0000);
		send_request(OP_GET,    32'hFFFF_FFFF);
		send_request(OP_GET,    32'h0000_0000);
		send_request(OP_FIND,   32'hFFFF_FFFF);
		send_request(OP_FIND,   32'h7FFF_FFFF);
		send_request(OP_UNUSED, 32'h8000_0000);
		send_request(OP_GET,    32'h5555_5555);
		send_request(OP_GET,    32'hAAAA_AAAA);
		send_request(OP_REMOVE, 32'h8000_0000);
		send_request(OP_REMOVE, 32'h8000_0000);
		send_request(OP_REMOVE, 32'h0000_0000);
		send_request(OP_REMOVE, 32'hFFFF_FFFF);
		send_request(OP_FIND,   32'hAAAA_AAAA);
		send_request(OP_GET,    32'h0000_0001);
		send_request(OP_GET,    32'hFFFF_FFFE);
		send_request(OP_REMOVE, 32'h5555_5555);
		send_request(OP_UNUSED, 32'h1234_5678);
		wait_drained();

		// fill past capacity, drain, refill, then a mixed run
		run_phase(200, 85, 5);
		wait_drained();
		run_phase(200, 5, 85);
		run_phase(150, 80, 10);
		wait_drained();
		run_phase(230, 40, 35);

		@(negedge clk);
		req_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
src/skt_pkg.sv
src/skt_ram.sv
src/skt_seq.sv
src/sorted_key_table.sv
verif/sorted_key_table_checker.sv
verif/sorted_key_table_tb.sv
